// ===== design/mnpt_pkg.sv =====
// ----------------------------------------------------------------------------
// mnpt_pkg
// Shared constants for the MIDI note pairing tracker: default sizes and the
// status byte codes that select note-on and note-off events.
// ----------------------------------------------------------------------------
package mnpt_pkg;

  localparam int NUM_KEYS_DEF  = 128;
  localparam int TIME_BITS_DEF = 32;

  localparam int STATUS_W = 8;
  localparam int KEY_W    = 7;
  localparam int VEL_W    = 7;
  localparam int EV_TIME_W = 32;
  localparam int OUT_TIME_W = 32;

  localparam logic [STATUS_W-1:0] STATUS_KIND_MASK = 8'hF0;
  localparam logic [STATUS_W-1:0] KIND_NOTE_ON     = 8'h90;
  localparam logic [STATUS_W-1:0] KIND_NOTE_OFF    = 8'h80;

endpackage

// ===== design/midi_note_pairing_tracker.sv =====
// ----------------------------------------------------------------------------
// midi_note_pairing_tracker
// Pairs time-ordered MIDI note-on and note-off events per key into notes.
//
// Usage:
//   Input words (status, key, velocity, event_time, last_event) arrive on
//   in_valid / in_stall; completed notes leave on out_valid / out_stall.
//   A word is taken at a rising edge with valid high and stall low.
//   Each word does one read-modify-write of its key's entry in a single
//   synchronous memory: the read is issued when the word is taken, and the
//   update and write-back, if any, happen as it leaves the processing stage.
//   A note enters the output register as its closing word leaves the stage.
//   The block takes one word per cycle unless a closing word waits on a
//   stalled output, and words on the same key back to back are bypassed.
//   A word that closes no note is dropped without using the output.
//   While the receiver stalls, the output register holds its note, and the
//   processing stage holds one more word; then in_stall rises.
//   Reset clears the pending and previous-off flags of every key; the memory
//   contents are left as they are. A word with last_event set clears those
//   flags for all keys after it has been handled.
// ----------------------------------------------------------------------------
module midi_note_pairing_tracker #(
  parameter int NUM_KEYS  = mnpt_pkg::NUM_KEYS_DEF,
  parameter int TIME_BITS = mnpt_pkg::TIME_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [mnpt_pkg::STATUS_W-1:0]      in_status,
  input  logic [mnpt_pkg::KEY_W-1:0]         in_key,
  input  logic [mnpt_pkg::VEL_W-1:0]         in_velocity,
  input  logic [mnpt_pkg::EV_TIME_W-1:0]     in_event_time,
  input  logic                               in_last_event,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [mnpt_pkg::KEY_W-1:0]         out_note_key,
  output logic [mnpt_pkg::VEL_W-1:0]         out_note_velocity,
  output logic [mnpt_pkg::OUT_TIME_W-1:0]    out_start_time,
  output logic [mnpt_pkg::OUT_TIME_W-1:0]    out_duration,
  output logic [mnpt_pkg::OUT_TIME_W-1:0]    out_corrected_start,
  output logic [mnpt_pkg::OUT_TIME_W-1:0]    out_corrected_end,
  output logic                               out_start_shifted,
  output logic                               out_ended_by_repeat
);

  localparam int TB      = TIME_BITS;
  localparam int VW      = mnpt_pkg::VEL_W;
  localparam int IDX_W   = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int ENTRY_W = 2 * TB + VW;

  // Entry layout: {on time, on velocity, last off time}.
  localparam int OFF_LSB = 0;
  localparam int VEL_LSB = TB;
  localparam int ON_LSB  = TB + VW;

  // Processing stage.
  logic                          s1_valid_r;
  logic [mnpt_pkg::STATUS_W-1:0] s1_status_r;
  logic [mnpt_pkg::KEY_W-1:0]    s1_key_r;
  logic [VW-1:0]                 s1_vel_r;
  logic [TB-1:0]                 s1_time_r;
  logic                          s1_last_r;

  logic [NUM_KEYS-1:0] pend_r, pend_nxt;
  logic [NUM_KEYS-1:0] off_vld_r, off_vld_nxt;

  logic               out_valid_r;
  logic [mnpt_pkg::KEY_W-1:0] out_key_r;
  logic [VW-1:0]      out_vel_r;
  logic [TB-1:0]      out_start_r, out_dur_r, out_cstart_r, out_cend_r;
  logic               out_shift_r, out_rep_r;

  logic                 in_acc;
  logic                 s1_adv;
  logic [IDX_W-1:0]     rd_idx, s1_idx;
  logic [ENTRY_W-1:0]   ent;
  logic [ENTRY_W-1:0]   wr_data;
  logic                 wr_en;

  logic [mnpt_pkg::STATUS_W-1:0] kind;
  logic          key_ok, is_on, is_off, act, starts, pend;
  logic          closes, start_new, shifted;
  logic [TB-1:0] ent_on, ent_off, prev_off, cstart, cend, dur;
  logic [VW-1:0] ent_vel;

  assign rd_idx = in_key[IDX_W-1:0];
  assign s1_idx = s1_key_r[IDX_W-1:0];

  mnpt_entry_ram #(
    .DEPTH  (NUM_KEYS),
    .ADDR_W (IDX_W),
    .DATA_W (ENTRY_W)
  ) u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (rd_idx),
    .wr_en   (wr_en),
    .wr_addr (s1_idx),
    .wr_data (wr_data),
    .rd_data (ent)
  );

  // Event decode and note arithmetic.
  always_comb begin
    kind      = s1_status_r & mnpt_pkg::STATUS_KIND_MASK;
    key_ok    = 32'(s1_key_r) < 32'(NUM_KEYS);
    is_on     = (kind == mnpt_pkg::KIND_NOTE_ON);
    is_off    = (kind == mnpt_pkg::KIND_NOTE_OFF);
    act       = key_ok && (is_on || is_off);
    starts    = is_on && (s1_vel_r != '0);
    pend      = pend_r[s1_idx];
    closes    = act && pend;
    start_new = act && starts && !pend;

    ent_on   = ent[ON_LSB +: TB];
    ent_vel  = ent[VEL_LSB +: VW];
    ent_off  = ent[OFF_LSB +: TB];
    // A previous off time that was cleared reads as zero, meaning none.
    prev_off = off_vld_r[s1_idx] ? ent_off : '0;
    shifted  = (prev_off != '0) && (ent_on < prev_off);
    cstart   = shifted ? prev_off : ent_on;
    cend     = (s1_time_r < cstart) ? cstart : s1_time_r;
    dur      = s1_time_r - ent_on;
  end

  assign s1_adv = s1_valid_r && (!closes || !out_valid_r || !out_stall);
  assign in_acc = in_valid && !in_stall;
  assign in_stall = s1_valid_r && !s1_adv;

  assign wr_en   = s1_adv && (start_new || closes);
  assign wr_data = start_new ? {s1_time_r, s1_vel_r, ent_off}
                             : {ent_on, ent_vel, s1_time_r};

  always_comb begin
    pend_nxt    = pend_r;
    off_vld_nxt = off_vld_r;
    if (s1_adv) begin
      if (start_new) begin
        pend_nxt[s1_idx] = 1'b1;
      end
      if (closes) begin
        pend_nxt[s1_idx]    = 1'b0;
        off_vld_nxt[s1_idx] = 1'b1;
      end
      if (s1_last_r) begin
        pend_nxt    = '0;
        off_vld_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= '0;
      off_vld_r <= '0;
    end else begin
      pend_r    <= pend_nxt;
      off_vld_r <= off_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_status_r <= in_status;
      s1_key_r    <= in_key;
      s1_vel_r    <= in_velocity;
      s1_time_r   <= TB'(in_event_time);
      s1_last_r   <= in_last_event;
    end
  end

  logic out_load;
  assign out_load = s1_adv && closes;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_key_r    <= s1_key_r;
      out_vel_r    <= ent_vel;
      out_start_r  <= ent_on;
      out_dur_r    <= dur;
      out_cstart_r <= cstart;
      out_cend_r   <= cend;
      out_shift_r  <= shifted;
      out_rep_r    <= starts;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_note_key        = out_key_r;
  assign out_note_velocity   = out_vel_r;
  assign out_start_time      = mnpt_pkg::OUT_TIME_W'(out_start_r);
  assign out_duration        = mnpt_pkg::OUT_TIME_W'(out_dur_r);
  assign out_corrected_start = mnpt_pkg::OUT_TIME_W'(out_cstart_r);
  assign out_corrected_end   = mnpt_pkg::OUT_TIME_W'(out_cend_r);
  assign out_start_shifted   = out_shift_r;
  assign out_ended_by_repeat = out_rep_r;

endmodule

// ===== design/mnpt_entry_ram.sv =====
// ----------------------------------------------------------------------------
// mnpt_entry_ram
// Per-key entry store: one write port, one registered read port, with a
// bypass that returns the data written at the same edge as the read.
// ----------------------------------------------------------------------------
module mnpt_entry_ram #(
  parameter int DEPTH  = mnpt_pkg::NUM_KEYS_DEF,
  parameter int ADDR_W = 7,
  parameter int DATA_W = 2 * mnpt_pkg::TIME_BITS_DEF + mnpt_pkg::VEL_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_q_r;
  logic [DATA_W-1:0] byp_data_r;
  logic              byp_hit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r     <= mem[rd_addr];
      byp_data_r <= wr_data;
    end
  end

  // A read at the same edge as a write to that entry sees the old contents,
  // so the written word is kept and substituted.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_hit_r <= 1'b0;
    end else if (rd_en) begin
      byp_hit_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = byp_hit_r ? byp_data_r : rd_q_r;

endmodule

// ===== test/midi_note_pairing_tracker_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// midi_note_pairing_tracker_test
// Self-checking bench for the MIDI note pairing tracker. A scoreboard keeps
// its own per-key view of pending notes, on times, velocities and previous
// off times, predicts each paired note from the accepted event words, and
// compares every note that leaves the block field by field. Stimulus is a
// directed opening followed by random tracks, with bursty input, patterned
// output stalls, long output hold-offs and drain pauses.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [mnpt_pkg::KEY_W-1:0]      key;
  logic [mnpt_pkg::VEL_W-1:0]      velocity;
  logic [mnpt_pkg::OUT_TIME_W-1:0] start_time;
  logic [mnpt_pkg::OUT_TIME_W-1:0] duration;
  logic [mnpt_pkg::OUT_TIME_W-1:0] corr_start;
  logic [mnpt_pkg::OUT_TIME_W-1:0] corr_end;
  logic                            shifted;
  logic                            by_repeat;
} paired_note_t;

class note_pairing_scoreboard;
  bit                           key_pending  [mnpt_pkg::NUM_KEYS_DEF];
  bit [mnpt_pkg::EV_TIME_W-1:0] key_on_time  [mnpt_pkg::NUM_KEYS_DEF];
  bit [mnpt_pkg::VEL_W-1:0]     key_on_vel   [mnpt_pkg::NUM_KEYS_DEF];
  bit [mnpt_pkg::EV_TIME_W-1:0] key_last_off [mnpt_pkg::NUM_KEYS_DEF];
  paired_note_t                 awaited_notes[$];
  int                           mismatch_count;

  function void clear_track();
    foreach (key_pending[k]) begin
      key_pending[k]  = 1'b0;
      key_last_off[k] = '0;
    end
  endfunction

  function string describe(paired_note_t n);
    return $sformatf("key=%0d vel=%0d start=%0h dur=%0h cstart=%0h cend=%0h shift=%0b rep=%0b",
                     n.key, n.velocity, n.start_time, n.duration, n.corr_start,
                     n.corr_end, n.shifted, n.by_repeat);
  endfunction

  // Updates the per-key view with one accepted event word.
  function void note_event(input logic [mnpt_pkg::STATUS_W-1:0] status,
                           input logic [mnpt_pkg::KEY_W-1:0] key,
                           input logic [mnpt_pkg::VEL_W-1:0] vel,
                           input logic [mnpt_pkg::EV_TIME_W-1:0] t,
                           input logic last);
    logic [mnpt_pkg::STATUS_W-1:0] kind;
    paired_note_t                  n;
    bit                            closes;
    bit                            by_rep;
    kind   = status & mnpt_pkg::STATUS_KIND_MASK;
    closes = 1'b0;
    by_rep = 1'b0;
    if (kind == mnpt_pkg::KIND_NOTE_ON || kind == mnpt_pkg::KIND_NOTE_OFF) begin
      if (kind == mnpt_pkg::KIND_NOTE_ON && vel != 0) begin
        if (key_pending[key]) begin
          closes = 1'b1;
          by_rep = 1'b1;
        end else begin
          key_pending[key] = 1'b1;
          key_on_time[key] = t;
          key_on_vel[key]  = vel;
        end
      end else if (key_pending[key]) begin
        closes = 1'b1;
      end
    end
    if (closes) begin
      n.key        = key;
      n.velocity   = key_on_vel[key];
      n.start_time = key_on_time[key];
      n.duration   = t - key_on_time[key];
      n.corr_start = key_on_time[key];
      n.shifted    = 1'b0;
      // A previous off time of zero means the key has not been released yet.
      if (key_last_off[key] != 0 && key_on_time[key] < key_last_off[key]) begin
        n.corr_start = key_last_off[key];
        n.shifted    = 1'b1;
      end
      n.corr_end  = (t < n.corr_start) ? n.corr_start : t;
      n.by_repeat = by_rep;
      key_last_off[key] = t;
      key_pending[key]  = 1'b0;
      awaited_notes.push_back(n);
    end
    if (last) clear_track();
  endfunction

  function void check_note(paired_note_t got);
    paired_note_t exp;
    string        bad;
    bad = "";
    if (awaited_notes.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10) $display("note with nothing awaited: %s", describe(got));
      return;
    end
    exp = awaited_notes.pop_front();
    if (got.key !== exp.key) bad = {bad, " key"};
    if (got.velocity !== exp.velocity) bad = {bad, " velocity"};
    if (got.start_time !== exp.start_time) bad = {bad, " start_time"};
    if (got.duration !== exp.duration) bad = {bad, " duration"};
    if (got.corr_start !== exp.corr_start) bad = {bad, " corrected_start"};
    if (got.corr_end !== exp.corr_end) bad = {bad, " corrected_end"};
    if (got.shifted !== exp.shifted) bad = {bad, " start_shifted"};
    if (got.by_repeat !== exp.by_repeat) bad = {bad, " ended_by_repeat"};
    if (bad != "") begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("note mismatch in%s\n  expected %s\n  actual   %s", bad, describe(exp),
                 describe(got));
    end
  endfunction
endclass

module midi_note_pairing_tracker_test;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int          NOTE_ITEMS  = 1850;
  localparam int          HOLD_CYCLES = 300;

  typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  logic [mnpt_pkg::STATUS_W-1:0]   in_status;
  logic [mnpt_pkg::KEY_W-1:0]      in_key;
  logic [mnpt_pkg::VEL_W-1:0]      in_velocity;
  logic [mnpt_pkg::EV_TIME_W-1:0]  in_event_time;
  logic                            in_last_event;
  logic                            out_valid;
  logic                            out_stall;
  logic [mnpt_pkg::KEY_W-1:0]      out_note_key;
  logic [mnpt_pkg::VEL_W-1:0]      out_note_velocity;
  logic [mnpt_pkg::OUT_TIME_W-1:0] out_start_time;
  logic [mnpt_pkg::OUT_TIME_W-1:0] out_duration;
  logic [mnpt_pkg::OUT_TIME_W-1:0] out_corrected_start;
  logic [mnpt_pkg::OUT_TIME_W-1:0] out_corrected_end;
  logic                            out_start_shifted;
  logic                            out_ended_by_repeat;

  note_pairing_scoreboard sb = new();
  int unsigned            cycle_count = 0;
  int                     burst_left  = 0;
  int                     note_items  = 0;
  bit                     hold_request = 1'b0;

  midi_note_pairing_tracker uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_status           (in_status),
    .in_key              (in_key),
    .in_velocity         (in_velocity),
    .in_event_time       (in_event_time),
    .in_last_event       (in_last_event),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_note_key        (out_note_key),
    .out_note_velocity   (out_note_velocity),
    .out_start_time      (out_start_time),
    .out_duration        (out_duration),
    .out_corrected_start (out_corrected_start),
    .out_corrected_end   (out_corrected_end),
    .out_start_shifted   (out_start_shifted),
    .out_ended_by_repeat (out_ended_by_repeat)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[midi_note_pairing_tracker] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_note('{out_note_key, out_note_velocity, out_start_time, out_duration,
                      out_corrected_start, out_corrected_end, out_start_shifted,
                      out_ended_by_repeat});
  end

  // Receiver: the stall pattern changes mode at random intervals; a hold
  // request keeps the output stalled for a long stretch.
  initial begin
    rx_mode_t mode;
    int       left;
    int       period;
    int       duty;
    int       hold_left;
    int       phase;
    out_stall = 1'b0;
    mode      = RX_FREE;
    left      = 0;
    period    = 2;
    duty      = 1;
    hold_left = 0;
    phase     = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (left == 0) begin
        mode   = rx_mode_t'($urandom_range(0, 3));
        left   = $urandom_range(50, 400);
        period = $urandom_range(2, 9);
        duty   = $urandom_range(1, period - 1);
      end
      left--;
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          RX_FREE:  out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:  out_stall <= ((phase % period) < duty);
        endcase
      end
    end
  end

  task automatic send_word(input logic [mnpt_pkg::STATUS_W-1:0] status,
                           input logic [mnpt_pkg::KEY_W-1:0] key,
                           input logic [mnpt_pkg::VEL_W-1:0] vel,
                           input logic [mnpt_pkg::EV_TIME_W-1:0] t,
                           input logic last);
    @(negedge clk);
    in_valid      <= 1'b1;
    in_status     <= status;
    in_key        <= key;
    in_velocity   <= vel;
    in_event_time <= t;
    in_last_event <= last;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_event(status, key, vel, t, last);
  endtask

  // Sends one word, inserting a random gap at the start of each burst unless
  // the word belongs to a back-to-back run.
  task automatic offer_word(input logic [mnpt_pkg::STATUS_W-1:0] status,
                            input logic [mnpt_pkg::KEY_W-1:0] key,
                            input logic [mnpt_pkg::VEL_W-1:0] vel,
                            input logic [mnpt_pkg::EV_TIME_W-1:0] t,
                            input logic last, input bit dense);
    if (!dense) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        if ($urandom_range(0, 3) != 0) begin
          @(negedge clk);
          in_valid <= 1'b0;
          repeat ($urandom_range(0, 11)) @(posedge clk);
        end
      end
      burst_left--;
    end
    send_word(status, key, vel, t, last);
  endtask

  // The sender goes idle first, so the last word is not taken again.
  task automatic wait_for_notes();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.awaited_notes.size() != 0) @(posedge clk);
  endtask

  // One track of events on a small cluster of keys with mostly rising times;
  // a few words are noise, jump back in time or end the track early.
  task automatic run_track(input int len, input bit dense);
    logic [mnpt_pkg::EV_TIME_W-1:0] t;
    logic [mnpt_pkg::KEY_W-1:0]     key_base;
    logic [mnpt_pkg::KEY_W-1:0]     key;
    logic [mnpt_pkg::STATUS_W-1:0]  status;
    logic [mnpt_pkg::VEL_W-1:0]     vel;
    logic                           last;
    int                             pick;
    t        = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2000);
    key_base = mnpt_pkg::KEY_W'($urandom);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 99);
      key  = ($urandom_range(0, 4) == 0) ? mnpt_pkg::KEY_W'($urandom)
             : key_base + mnpt_pkg::KEY_W'($urandom_range(0, 3));
      vel  = mnpt_pkg::VEL_W'($urandom_range(1, 127));
      if (pick < 50) begin
        status = mnpt_pkg::KIND_NOTE_ON | mnpt_pkg::STATUS_W'($urandom_range(0, 15));
      end else if (pick < 80) begin
        status = mnpt_pkg::KIND_NOTE_OFF | mnpt_pkg::STATUS_W'($urandom_range(0, 15));
        vel    = mnpt_pkg::VEL_W'($urandom);
      end else if (pick < 90) begin
        status = mnpt_pkg::KIND_NOTE_ON | mnpt_pkg::STATUS_W'($urandom_range(0, 15));
        vel    = '0;
      end else begin
        status = mnpt_pkg::STATUS_W'($urandom_range(0, 255));
        vel    = mnpt_pkg::VEL_W'($urandom);
      end
      if ($urandom_range(0, 49) == 0) t = $urandom;
      else if ($urandom_range(0, 2) != 0) t = t + $urandom_range(1, 60);
      last = (i == len - 1) || ($urandom_range(0, 199) == 0);
      offer_word(status, key, vel, t, last, dense);
      note_items++;
    end
  endtask

  initial begin
    int track_no;
    track_no      = 0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_status     = '0;
    in_key        = '0;
    in_velocity   = '0;
    in_event_time = '0;
    in_last_event = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Plain note, then a note closed by a repeated note-on.
    offer_word(mnpt_pkg::KIND_NOTE_ON, 7'd0, 7'd127, 32'd0, 1'b0, 1'b0);
    offer_word(mnpt_pkg::KIND_NOTE_OFF, 7'd0, 7'd0, 32'd10, 1'b0, 1'b0);
    offer_word(mnpt_pkg::KIND_NOTE_ON | 8'h0F, 7'd0, 7'd1, 32'd20, 1'b0, 1'b0);
    offer_word(mnpt_pkg::KIND_NOTE_ON | 8'h03, 7'd0, 7'd5, 32'd30, 1'b0, 1'b0);
    // Releases on idle keys and words of other kinds give nothing.
    offer_word(mnpt_pkg::KIND_NOTE_ON | 8'h05, 7'd0, 7'd0, 32'd40, 1'b0, 1'b0);
    offer_word(mnpt_pkg::KIND_NOTE_OFF | 8'h0A, 7'd127, 7'd127, 32'd40, 1'b0, 1'b0);
    offer_word(8'hFF, 7'd5, 7'd3, 32'd45, 1'b0, 1'b0);
    offer_word(mnpt_pkg::STATUS_KIND_MASK, 7'd5, 7'd3, 32'd45, 1'b0, 1'b0);
    offer_word(8'h00, 7'd5, 7'd3, 32'd45, 1'b0, 1'b0);
    offer_word(8'h7F, 7'd5, 7'd3, 32'd45, 1'b0, 1'b0);
    offer_word(8'hA0, 7'd5, 7'd3, 32'd45, 1'b0, 1'b0);
    // Note-on with zero velocity closes; the next note starts before that
    // off time and ends before it, so its start is raised and its end clamped.
    offer_word(mnpt_pkg::KIND_NOTE_ON, 7'd127, 7'd64, 32'd50, 1'b0, 1'b0);
    offer_word(mnpt_pkg::KIND_NOTE_ON, 7'd127, 7'd0, 32'd60, 1'b0, 1'b0);
    offer_word(mnpt_pkg::KIND_NOTE_ON, 7'd127, 7'd10, 32'd55, 1'b0, 1'b0);
    offer_word(mnpt_pkg::KIND_NOTE_OFF, 7'd127, 7'd0, 32'd58, 1'b0, 1'b0);
    // Off time below on time: the duration wraps.
    offer_word(mnpt_pkg::KIND_NOTE_ON, 7'd64, 7'd7, 32'hFFFF_FFF0, 1'b0, 1'b0);
    offer_word(mnpt_pkg::KIND_NOTE_OFF, 7'd64, 7'd0, 32'h0000_0005, 1'b0, 1'b0);
    // Closing word that also ends the track.
    offer_word(mnpt_pkg::KIND_NOTE_ON, 7'd1, 7'd2, 32'hFFFF_FFFF, 1'b0, 1'b0);
    offer_word(mnpt_pkg::KIND_NOTE_OFF | 8'h0F, 7'd1, 7'd127, 32'hFFFF_FFFF, 1'b1, 1'b0);
    offer_word(mnpt_pkg::KIND_NOTE_OFF, 7'd1, 7'd0, 32'd1, 1'b0, 1'b0);
    // After the clear, the earlier off time of key 127 no longer shifts.
    offer_word(mnpt_pkg::KIND_NOTE_ON, 7'd127, 7'd3, 32'd5, 1'b0, 1'b0);
    offer_word(mnpt_pkg::KIND_NOTE_OFF, 7'd127, 7'd0, 32'd6, 1'b0, 1'b0);
    // A note left open at the end of a track is dropped.
    offer_word(mnpt_pkg::KIND_NOTE_ON, 7'd127, 7'd3, 32'd7, 1'b1, 1'b0);
    offer_word(mnpt_pkg::KIND_NOTE_OFF, 7'd127, 7'd0, 32'd9, 1'b0, 1'b0);
    wait_for_notes();

    while (note_items < NOTE_ITEMS) begin
      track_no++;
      if (track_no % 12 == 3) begin
        // Output held off while words keep coming, so the block backs up.
        hold_request = 1'b1;
        run_track(60, 1'b1);
      end else begin
        run_track($urandom_range(4, 60), 1'b0);
      end
      if (track_no % 9 == 0) wait_for_notes();
    end

    wait_for_notes();
    repeat (10) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.awaited_notes.size() == 0) begin
      $display("[midi_note_pairing_tracker] OK");
    end else begin
      $display("[midi_note_pairing_tracker] ERROR");
    end
    $finish;
  end

endmodule
